>>> design/stftdb_pkg.sv
// ----------------------------------------------------------------------------
// stftdb_pkg: shared constants and table functions
// Field widths, the dB scaling constants and the elaboration-time sine used
// to build the window and twiddle tables.
// ----------------------------------------------------------------------------
package stftdb_pkg;

  localparam int WIN_LEN_DEF  = 64;
  localparam int SAMPLE_W     = 16;
  localparam int BIN_W        = 12;
  localparam int DB_W         = 17;
  localparam int FRAME_W      = 16;
  localparam int WORD_W       = 32;
  localparam int COEF_W       = 17;
  localparam int MUL_W        = 33;

  localparam logic signed [DB_W-1:0] DB_FLOOR = -17'sd51200;
  localparam logic signed [DB_W-1:0] DB_MAX   = 17'sd32767;
  localparam logic [17:0]            DB_K     = 18'd197283;
  localparam logic [63:0]            PI_HALF_Q30 = 64'd1686629713;

  // Sine of t (units of 2^-32 turn) in Q30, 8-term Taylor series on the
  // reduced quarter-turn angle, clamped to [0, 1] before the sign.
  function automatic logic signed [31:0] sin_q30(input logic [31:0] t);
    logic [1:0]         q;
    logic [31:0]        r;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    q = t[31:30];
    r = {2'b00, t[29:0]};
    if (q[0]) begin
      r = 32'h4000_0000 - r;
    end
    x = (64'(r) * PI_HALF_Q30) >> 30;
    term = x;
    sum = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    if (q[1]) begin
      sum = -sum;
    end
    return 32'(sum);
  endfunction

  // Q30 to Q15 with rounding (add half, floor).
  function automatic logic signed [COEF_W-1:0] q15_round(input logic signed [31:0] v);
    logic signed [63:0] a;
    a = 64'(v) + 64'sd16384;
    return COEF_W'(a >>> 15);
  endfunction

  // Hann coefficient from the cosine value in Q30.
  function automatic logic signed [COEF_W-1:0] win_val(input logic signed [31:0] c);
    logic signed [63:0] a;
    a = 64'sd1073741824 - 64'(c) + 64'sd32768;
    return COEF_W'(a >>> 16);
  endfunction

endpackage

>>> design/stft_power_spectrum_db_unit.sv
// ----------------------------------------------------------------------------
// stft_power_spectrum_db_unit: streaming STFT power spectrum in dB
// Hann window, in-place radix-2 DIT FFT and 20*log10 magnitude per bin,
// all on one shared multiplier under a sequencer.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | sample, last_sample
//   out     | out_valid,out_stall| bin_index, power_db, frame_number, last_bin
//
// An item that builds no frame leaves the unit idle and ready for the next one.
// A frame stalls the input while the window pass, the butterflies and the
// per-bin power and log steps run in turn on the one multiplier and the one-port
// work memory; a zero bin skips the log steps and gives the dB floor.
// Reset is synchronous and clears the fill state; no clearing pass is needed.
// A stalled output holds the bin sequencer until the result is taken.
// ----------------------------------------------------------------------------
module stft_power_spectrum_db_unit #(
  parameter int WIN_LEN = stftdb_pkg::WIN_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [stftdb_pkg::SAMPLE_W-1:0] sample,
  input  logic                                   last_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [stftdb_pkg::BIN_W-1:0]           bin_index,
  output logic signed [stftdb_pkg::DB_W-1:0]     power_db,
  output logic [stftdb_pkg::FRAME_W-1:0]         frame_number,
  output logic                                   last_bin
);

  localparam int LOG2N  = $clog2(WIN_LEN);
  localparam int SW     = $clog2(LOG2N);
  localparam int HOP_W  = LOG2N - 2;
  localparam int FILL_W = LOG2N + 1;
  localparam int WW     = stftdb_pkg::WORD_W;
  localparam int CW     = stftdb_pkg::COEF_W;
  localparam int MW     = stftdb_pkg::MUL_W;

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_WIN_RD = 25'h0000002,
    S_WIN_MUL= 25'h0000004,
    S_WIN_WR = 25'h0000008,
    S_BF_RDV = 25'h0000010,
    S_BF_RDU = 25'h0000020,
    S_BF_M1  = 25'h0000040,
    S_BF_M2  = 25'h0000080,
    S_BF_M3  = 25'h0000100,
    S_BF_M4  = 25'h0000200,
    S_BF_M5  = 25'h0000400,
    S_BF_TI  = 25'h0000800,
    S_BF_WRU = 25'h0001000,
    S_BF_WRV = 25'h0002000,
    S_P_RD   = 25'h0004000,
    S_P_SQR  = 25'h0008000,
    S_P_SQI  = 25'h0010000,
    S_P_SUM  = 25'h0020000,
    S_P_NORM = 25'h0040000,
    S_L_SQ   = 25'h0080000,
    S_L_ACC  = 25'h0100000,
    S_DB_MUL = 25'h0200000,
    S_DB_RND = 25'h0400000,
    S_P_OUT  = 25'h0800000,
    S_SPARE  = 25'h1000000
  } state_t;

  state_t state;

  // Control registers.
  logic [LOG2N-1:0]  wptr;
  logic [LOG2N-1:0]  idx;
  logic [LOG2N-2:0]  bf;
  logic [SW-1:0]     stg;
  logic [3:0]        cnt;
  logic [FILL_W-1:0] fill;
  logic [HOP_W-1:0]  hop;
  logic [stftdb_pkg::FRAME_W-1:0] frame_counter;

  // Datapath registers.
  logic signed [stftdb_pkg::SAMPLE_W-1:0] hist [WIN_LEN];
  logic signed [stftdb_pkg::SAMPLE_W-1:0] hist_q;
  logic signed [WW-1:0] work_re [WIN_LEN];
  logic signed [WW-1:0] work_im [WIN_LEN];
  logic signed [WW-1:0] rd_re;
  logic signed [WW-1:0] rd_im;
  logic signed [WW-1:0] vr, vi, ur, ui;
  logic signed [2*MW-1:0] mul_q;
  logic signed [2*MW-1:0] acc;
  logic signed [34:0] tr, ti;
  logic [63:0] pw;
  logic [5:0]  e;
  logic [30:0] m;
  logic [15:0] f;
  logic signed [stftdb_pkg::DB_W-1:0] db_r;
  logic [stftdb_pkg::FRAME_W-1:0] frame_num;

  // Combinational signals.
  logic accept, out_free, frame_go;
  logic [FILL_W-1:0] fill_next;
  logic [HOP_W-1:0]  hop_next;
  logic [LOG2N-2:0]  bf_mask, bf_lo, tw_idx;
  logic [LOG2N-1:0]  bf_u, bf_v, idx_rev;
  logic signed [CW-1:0] win, tw_cos, tw_sin;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] acc_rnd, win_rnd, db_rnd, db_sh;
  logic signed [34:0] t_val;
  logic signed [22:0] db_l;
  logic [31:0] m2;
  logic wk_we, wk_rd;
  logic [LOG2N-1:0] wk_wa, wk_ra;
  logic signed [WW-1:0] wd_re, wd_im;

  function automatic logic signed [WW-1:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return WW'(v);
  endfunction

  stftdb_rom #(.WIN_LEN(WIN_LEN)) u_rom (
    .win_idx (idx),
    .tw_idx  (tw_idx),
    .win     (win),
    .tw_cos  (tw_cos),
    .tw_sin  (tw_sin)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Butterfly addressing: u has a zero inserted at bit stg, v a one.
  always_comb begin
    bf_mask = (LOG2N-1)'((1 << stg) - 1);
    bf_lo   = bf & bf_mask;
    bf_u    = (LOG2N'(bf >> stg) << (int'(stg) + 1)) | LOG2N'(bf_lo);
    bf_v    = bf_u | LOG2N'(1 << stg);
    tw_idx  = (LOG2N-1)'(bf_lo << (LOG2N - 1 - int'(stg)));
    for (int b = 0; b < LOG2N; b++) begin
      idx_rev[b] = idx[LOG2N-1-b];
    end
  end

  // Fill and hop bookkeeping for an accepted item.
  always_comb begin
    fill_next = fill;
    hop_next  = hop;
    frame_go  = 1'b0;
    if (fill != FILL_W'(WIN_LEN)) begin
      fill_next = fill + 1'b1;
      if (fill_next == FILL_W'(WIN_LEN)) begin
        frame_go = 1'b1;
        hop_next = '0;
      end
    end else if (hop == HOP_W'(WIN_LEN/4 - 1)) begin
      frame_go = 1'b1;
      hop_next = '0;
    end else begin
      hop_next = hop + 1'b1;
    end
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_WIN_MUL: begin
        mul_a = MW'(hist_q);
        mul_b = MW'(win);
      end
      S_BF_M1: begin
        mul_a = MW'(tw_cos);
        mul_b = MW'(vr);
      end
      S_BF_M2: begin
        mul_a = MW'(tw_sin);
        mul_b = MW'(vi);
      end
      S_BF_M3: begin
        mul_a = MW'(tw_cos);
        mul_b = MW'(vi);
      end
      S_BF_M4: begin
        mul_a = MW'(tw_sin);
        mul_b = MW'(vr);
      end
      S_P_SQR: begin
        mul_a = MW'(rd_re);
        mul_b = MW'(rd_re);
      end
      S_P_SQI: begin
        mul_a = MW'(rd_im);
        mul_b = MW'(rd_im);
      end
      S_L_SQ: begin
        mul_a = $signed({2'b00, m});
        mul_b = $signed({2'b00, m});
      end
      S_DB_MUL: begin
        mul_a = MW'(db_l);
        mul_b = $signed({15'd0, stftdb_pkg::DB_K});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_rnd = acc + 66'sd16384;
    t_val   = acc_rnd[49:15];
    win_rnd = mul_q + 66'sd16384;
    db_rnd  = mul_q + 66'sd8388608;
    db_sh   = db_rnd >>> 24;
    db_l    = $signed({1'b0, e, f}) - 23'sd1966080;
    m2      = mul_q[61:30];
  end

  // Work memory port control.
  always_comb begin
    wk_we = 1'b0;
    wk_wa = bf_u;
    wd_re = sat32(35'(ur) + tr);
    wd_im = sat32(35'(ui) + ti);
    wk_rd = 1'b0;
    wk_ra = idx;
    unique case (state)
      S_WIN_WR: begin
        wk_we = 1'b1;
        wk_wa = idx_rev;
        wd_re = win_rnd[46:15];
        wd_im = '0;
      end
      S_BF_WRU: begin
        wk_we = 1'b1;
      end
      S_BF_WRV: begin
        wk_we = 1'b1;
        wk_wa = bf_v;
        wd_re = sat32(35'(ur) - tr);
        wd_im = sat32(35'(ui) - ti);
      end
      S_BF_RDV: begin
        wk_rd = 1'b1;
        wk_ra = bf_v;
      end
      S_BF_RDU: begin
        wk_rd = 1'b1;
        wk_ra = bf_u;
      end
      S_P_RD: begin
        wk_rd = 1'b1;
      end
      default: begin
        wk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist[wptr] <= sample;
    end
    if (state == S_WIN_RD) begin
      hist_q <= hist[wptr + idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      work_re[wk_wa] <= wd_re;
      work_im[wk_wa] <= wd_im;
    end
    if (wk_rd) begin
      rd_re <= work_re[wk_ra];
      rd_im <= work_im[wk_ra];
    end
  end

  // A new bin is posted only when the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_P_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wptr          <= '0;
      idx           <= '0;
      bf            <= '0;
      stg           <= '0;
      cnt           <= '0;
      fill          <= '0;
      hop           <= '0;
      frame_counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wptr <= wptr + 1'b1;
            if (frame_go) begin
              idx   <= '0;
              state <= S_WIN_RD;
            end
            if (last_sample) begin
              fill          <= '0;
              hop           <= '0;
              frame_counter <= '0;
            end else begin
              fill <= fill_next;
              hop  <= hop_next;
              if (frame_go) begin
                frame_counter <= frame_counter + 1'b1;
              end
            end
          end
        end
        S_WIN_RD:  state <= S_WIN_MUL;
        S_WIN_MUL: state <= S_WIN_WR;
        S_WIN_WR: begin
          idx <= idx + 1'b1;
          if (idx == LOG2N'(WIN_LEN - 1)) begin
            bf    <= '0;
            stg   <= '0;
            state <= S_BF_RDV;
          end else begin
            state <= S_WIN_RD;
          end
        end
        S_BF_RDV: state <= S_BF_RDU;
        S_BF_RDU: state <= S_BF_M1;
        S_BF_M1:  state <= S_BF_M2;
        S_BF_M2:  state <= S_BF_M3;
        S_BF_M3:  state <= S_BF_M4;
        S_BF_M4:  state <= S_BF_M5;
        S_BF_M5:  state <= S_BF_TI;
        S_BF_TI:  state <= S_BF_WRU;
        S_BF_WRU: state <= S_BF_WRV;
        S_BF_WRV: begin
          bf <= bf + 1'b1;
          if (bf == '1) begin
            if (stg == SW'(LOG2N - 1)) begin
              idx   <= '0;
              state <= S_P_RD;
            end else begin
              stg   <= stg + 1'b1;
              state <= S_BF_RDV;
            end
          end else begin
            state <= S_BF_RDV;
          end
        end
        S_P_RD:  state <= S_P_SQR;
        S_P_SQR: state <= S_P_SQI;
        S_P_SQI: state <= S_P_SUM;
        S_P_SUM: state <= S_P_NORM;
        S_P_NORM: begin
          if (pw == '0) begin
            state <= S_P_OUT;
          end else if (pw[63]) begin
            cnt   <= '0;
            state <= S_L_SQ;
          end
        end
        S_L_SQ: state <= S_L_ACC;
        S_L_ACC: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            state <= S_DB_MUL;
          end else begin
            state <= S_L_SQ;
          end
        end
        S_DB_MUL: state <= S_DB_RND;
        S_DB_RND: state <= S_P_OUT;
        S_P_OUT: begin
          if (out_free) begin
            idx <= idx + 1'b1;
            if (idx == LOG2N'(WIN_LEN/2)) begin
              state <= S_IDLE;
            end else begin
              state <= S_P_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (accept && frame_go) begin
      frame_num <= frame_counter;
    end
    unique case (state)
      S_BF_RDU: begin
        vr <= rd_re;
        vi <= rd_im;
      end
      S_BF_M1: begin
        ur <= rd_re;
        ui <= rd_im;
      end
      S_BF_M2: acc <= mul_q;
      S_BF_M3: acc <= acc + mul_q;
      S_BF_M4: begin
        tr  <= t_val;
        acc <= mul_q;
      end
      S_BF_M5: acc <= acc - mul_q;
      S_BF_TI: ti <= t_val;
      S_P_SQI: pw <= mul_q[63:0];
      S_P_SUM: begin
        pw <= pw + mul_q[63:0];
        e  <= 6'd63;
      end
      S_P_NORM: begin
        // Normalize so bit 63 is set; the top 31 bits are the Q30 mantissa.
        if (pw == '0) begin
          db_r <= stftdb_pkg::DB_FLOOR;
        end else if (pw[63:56] == 8'd0) begin
          pw <= pw << 8;
          e  <= e - 6'd8;
        end else if (!pw[63]) begin
          pw <= pw << 1;
          e  <= e - 6'd1;
        end else begin
          m <= pw[63:33];
          f <= '0;
        end
      end
      S_L_ACC: begin
        f <= {f[14:0], m2[31]};
        m <= m2[31] ? m2[31:1] : m2[30:0];
      end
      S_DB_RND: begin
        if (db_sh < 66'(stftdb_pkg::DB_FLOOR)) begin
          db_r <= stftdb_pkg::DB_FLOOR;
        end else if (db_sh > 66'(stftdb_pkg::DB_MAX)) begin
          db_r <= stftdb_pkg::DB_MAX;
        end else begin
          db_r <= stftdb_pkg::DB_W'(db_sh);
        end
      end
      S_P_OUT: begin
        if (out_free) begin
          bin_index    <= stftdb_pkg::BIN_W'(idx);
          power_db     <= db_r;
          frame_number <= frame_num;
          last_bin     <= (idx == LOG2N'(WIN_LEN/2));
        end
      end
      default: begin
      end
    endcase
  end

  a_last_bin_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_bin |-> bin_index == stftdb_pkg::BIN_W'(WIN_LEN/2))
    else $error("last_bin on a bin other than the top one");

  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && $past(state == S_IDLE) |-> $past(in_valid && !in_stall))
    else $error("frame started without an accepted item");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WIN_LEN))
    else $error("fill count beyond window size");

  a_first_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && fill == FILL_W'(WIN_LEN - 1) |=> state == S_WIN_RD)
    else $error("full window did not start a frame");

endmodule

>>> design/stftdb_rom.sv
// ----------------------------------------------------------------------------
// stftdb_rom: Hann window and twiddle tables
// Constant tables built at elaboration; one window and one twiddle read.
// ----------------------------------------------------------------------------
module stftdb_rom #(
  parameter int WIN_LEN = stftdb_pkg::WIN_LEN_DEF
) (
  input  logic [$clog2(WIN_LEN)-1:0]                win_idx,
  input  logic [$clog2(WIN_LEN)-2:0]                tw_idx,
  output logic signed [stftdb_pkg::COEF_W-1:0]      win,
  output logic signed [stftdb_pkg::COEF_W-1:0]      tw_cos,
  output logic signed [stftdb_pkg::COEF_W-1:0]      tw_sin
);

  localparam logic [63:0] TW_STEP = 64'h1_0000_0000 / WIN_LEN;

  logic signed [stftdb_pkg::COEF_W-1:0] win_rom [WIN_LEN];
  logic signed [stftdb_pkg::COEF_W-1:0] cos_rom [WIN_LEN/2];
  logic signed [stftdb_pkg::COEF_W-1:0] sin_rom [WIN_LEN/2];

  for (genvar gk = 0; gk < WIN_LEN/2; gk++) begin : g_tw
    localparam logic [63:0] TT = 64'(gk) * TW_STEP;
    assign cos_rom[gk] = stftdb_pkg::q15_round(stftdb_pkg::sin_q30(TT[31:0] + 32'h4000_0000));
    assign sin_rom[gk] = stftdb_pkg::q15_round(stftdb_pkg::sin_q30(TT[31:0]));
  end

  for (genvar gi = 0; gi < WIN_LEN; gi++) begin : g_win
    localparam logic [63:0] WT = (64'(gi) << 32) / 64'(WIN_LEN - 1);
    assign win_rom[gi] = stftdb_pkg::win_val(stftdb_pkg::sin_q30(WT[31:0] + 32'h4000_0000));
  end

  assign win    = win_rom[win_idx];
  assign tw_cos = cos_rom[tw_idx];
  assign tw_sin = sin_rom[tw_idx];

endmodule
